FILE: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int FUNC_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int IDX_W    = 11;
  localparam int OCOL_W   = 7;
  localparam int OROW_W   = 5;
  localparam int LOC_W    = 11;
  localparam int CELL_W   = 16;
  localparam int ATTR_W   = 8;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

  localparam logic [CELL_W-1:0] CLEAR_BLANK = 16'h0F20;

  localparam int TAB_STEP = 8;

endpackage

FILE: rtl/text_console_char_writer.sv
// Text console writer over a COLUMNS x ROWS screen of 16-bit cells (attribute in
// bits 15..8, character in 7..0) held in one synchronous RAM. Each transfer on the
// input carries func in in_tuser (0 put byte, 1 read cell, 2 clear) and returns
// exactly one result with the cursor after the item and, for reads, the cell.
// Items are handled one at a time: a put without scroll passes EXEC and DONE
// before its result is registered; a read also passes RDWAIT to wait for the
// registered RAM output. A put that pushes the cursor past the last row scrolls
// the screen by copying one cell per cycle through the RAM's single read port
// and single write port, then blanks the bottom row. A clear writes one cell per
// cycle over the whole screen. The attribute register may be written only while
// the block is idle. Cells read before they were ever written return undefined data.
module text_console_char_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [1:0] func
  input  logic [tcw_pkg::FUNC_W-1:0]      in_tuser,
  // [7:0] char_code, [18:8] cell_index, [23:19] zero
  input  logic [tcw_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [6:0] cursor_col, [11:7] cursor_row, [22:12] cursor_location,
  // [38:23] read_data, [39] zero
  output logic [tcw_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [tcw_pkg::ATTR_W-1:0]      cfg_wr_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int NW    = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]                        state_r, state_nxt;
  logic [CW-1:0]                     col_r, col_nxt;
  logic [RW-1:0]                     row_r, row_nxt;
  logic [tcw_pkg::ATTR_W-1:0]        attr_r;
  logic [tcw_pkg::FUNC_W-1:0]        func_r;
  logic [tcw_pkg::CHAR_W-1:0]        ch_r;
  logic [tcw_pkg::IDX_W-1:0]         idx_r;
  logic [tcw_pkg::CELL_W-1:0]        data_r, data_nxt;
  logic [NW-1:0]                     cnt_r, cnt_nxt;
  logic                              mv_pend_r, mv_pend_nxt;
  logic [AW-1:0]                     mv_addr_r, mv_addr_nxt;
  logic                              out_valid_r;
  logic [tcw_pkg::OUT_DATA_W-1:0]    out_data_r;

  logic                              ram_we;
  logic [AW-1:0]                     ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]        ram_wdata;
  logic [AW-1:0]                     ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]        ram_rdata;

  logic [CW:0]                       col_w;
  logic [RW:0]                       row_w;
  logic                              in_xfer;
  logic                              out_load;
  logic [tcw_pkg::CELL_W-1:0]        blank;
  logic [tcw_pkg::LOC_W-1:0]         loc;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign blank     = {attr_r, tcw_pkg::CH_SPACE};
  assign loc       = tcw_pkg::LOC_W'(row_r * COLUMNS + col_r);

  always_comb begin
    state_nxt   = state_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    data_nxt    = data_r;
    cnt_nxt     = cnt_r;
    mv_pend_nxt = 1'b0;
    mv_addr_nxt = mv_addr_r;
    ram_we      = 1'b0;
    ram_waddr   = AW'(row_r * COLUMNS + col_r);
    ram_wdata   = {attr_r, ch_r};
    ram_raddr   = AW'(cnt_r);
    col_w       = {1'b0, col_r};
    row_w       = {1'b0, row_r};

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        data_nxt  = '0;
        state_nxt = S_DONE;
        case (func_r)
          tcw_pkg::FUNC_PUT: begin
            case (ch_r)
              tcw_pkg::CH_BS: begin
                if (col_r != '0) begin
                  col_w = col_w - 1'b1;
                end
              end
              tcw_pkg::CH_TAB: begin
                col_w = (col_w + (CW+1)'(tcw_pkg::TAB_STEP))
                        & ~(CW+1)'(tcw_pkg::TAB_STEP - 1);
              end
              tcw_pkg::CH_CR: begin
                col_w = '0;
              end
              tcw_pkg::CH_LF: begin
                col_w = '0;
                row_w = row_w + 1'b1;
              end
              default: begin
                if (ch_r inside {[tcw_pkg::CH_SPACE:tcw_pkg::CH_LAST]}) begin
                  ram_we = 1'b1;
                  col_w  = col_w + 1'b1;
                end
              end
            endcase
            if (col_w >= (CW+1)'(COLUMNS)) begin
              col_w = '0;
              row_w = row_w + 1'b1;
            end
            col_nxt = CW'(col_w);
            if (row_w >= (RW+1)'(ROWS)) begin
              row_nxt   = RW'(ROWS - 1);
              cnt_nxt   = NW'(COLUMNS);
              state_nxt = S_SCROLL;
            end else begin
              row_nxt = RW'(row_w);
            end
          end
          tcw_pkg::FUNC_READ: begin
            if (32'(idx_r) < CELLS) begin
              ram_raddr = AW'(idx_r);
              state_nxt = S_RDWAIT;
            end
          end
          tcw_pkg::FUNC_CLEAR: begin
            col_nxt   = '0;
            row_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_CLEAR;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_RDWAIT: begin
        data_nxt  = ram_rdata;
        state_nxt = S_DONE;
      end
      S_SCROLL: begin
        ram_we    = mv_pend_r;
        ram_waddr = mv_addr_r;
        ram_wdata = ram_rdata;
        if (cnt_r < NW'(CELLS)) begin
          mv_pend_nxt = 1'b1;
          mv_addr_nxt = AW'(cnt_r - NW'(COLUMNS));
          cnt_nxt     = cnt_r + 1'b1;
        end else begin
          cnt_nxt   = NW'(CELLS - COLUMNS);
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cnt_r);
        ram_wdata = blank;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == NW'(CELLS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cnt_r);
        ram_wdata = tcw_pkg::CLEAR_BLANK;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == NW'(CELLS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= '0;
      mv_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      mv_pend_r <= mv_pend_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r    <= data_nxt;
    cnt_r     <= cnt_nxt;
    mv_addr_r <= mv_addr_nxt;
    if (in_xfer) begin
      func_r <= in_tuser;
      ch_r   <= in_tdata[7:0];
      idx_r  <= in_tdata[18:8];
    end
    if (out_load) begin
      out_data_r <= {1'b0, data_r, loc, tcw_pkg::OROW_W'(row_r),
                     tcw_pkg::OCOL_W'(col_r)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/tcw_checker.sv
`include "assert_macros.svh"

module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tcw_pkg::OUT_DATA_W-1:0]  out_tdata
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
               out_tvalid && $stable(out_tdata))

  `ASSERT_IMPLIES(a_cursor_range, clk, rst_n, out_tvalid,
                  (32'(out_tdata[6:0]) < COLUMNS) && (32'(out_tdata[11:7]) < ROWS))

  `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready)

endmodule

bind text_console_char_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
